// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define ASSERT_CLKD(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("check failed");

// Clocked check that also holds around reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("check failed");

`endif

// ===== rtl/lzcwd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ control word decompressor package
// Shared constants, parse phase encoding and pipeline word types.
// ----------------------------------------------------------------------------
package lzcwd_pkg;

    localparam int HIST_DEPTH = 32768;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        PH_CW_LO        = 4'd0,
        PH_CW_HI        = 4'd1,
        PH_BLOCK        = 4'd2,
        PH_LITW2        = 4'd3,
        PH_REP_LEN_HI   = 4'd4,
        PH_REP_VAL      = 4'd5,
        PH_COPY_LEN_HI  = 4'd6,
        PH_COPY_DIST_LO = 4'd7,
        PH_COPY_DIST_HI = 4'd8,
        PH_RUN_REP      = 4'd9,
        PH_RUN_COPY     = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        BT_LIT_BYTE = 2'd0,
        BT_LIT_WORD = 2'd1,
        BT_REPEAT   = 2'd2,
        BT_COPY     = 2'd3
    } block_type_t;

    // One step leaving the parse stage toward the history stage.
    typedef struct packed {
        logic               ov;
        logic [7:0]         val;
        logic               copy_rd;
        logic               fwd;
        logic               bad;
        logic               taken;
        logic               run_active;
        logic [HIST_AW-1:0] addr;
    } step_t;

    // One finished result word.
    typedef struct packed {
        logic       ov;
        logic [7:0] data;
        logic       taken;
        logic       bad;
        logic       run_active;
    } result_t;

endpackage

// ===== rtl/lz_control_word_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// LZ control word decompressor core
// Parses the compressed stream one word per step and expands repeats and
// copies through a history memory of decoded bytes.
// ----------------------------------------------------------------------------
//  Channel | Ports                                     | Direction
//  --------+-------------------------------------------+----------
//  input   | s_valid s_ready s_in_valid s_in_byte      | in
//          | s_start_req                               |
//  result  | m_valid m_ready m_out_valid m_out_byte    | out
//          | m_in_taken m_bad_distance m_run_active    |
//
// One input word is taken per cycle while s_ready is high and gives exactly one result word.
// A taken word is first registered as a history stage step and is then written
// into the result queue, from where it can be handed out. The history read of a
// copy step is issued at the edge that takes the word, with the byte written by
// the step just ahead forwarded around the memory.
// Reset is synchronous; the history memory is not cleared.
// s_ready falls only when the four-entry result queue could overflow.
module lz_control_word_decompressor_core import lzcwd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_in_valid,
    input  logic [7:0] s_in_byte,
    input  logic       s_start_req,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_valid,
    output logic [7:0] m_out_byte,
    output logic       m_in_taken,
    output logic       m_bad_distance,
    output logic       m_run_active
);

    phase_t             phase_reg, phase_next, ph_cur;
    logic [15:0]        ctrl_reg, ctrl_next, ctrl_cur;
    logic [3:0]         blocks_reg, blocks_next, blocks_cur, blocks_dec;
    logic [14:0]        run_rem_reg, run_rem_next, run_rem_cur;
    logic [7:0]         run_val_reg, run_val_next, run_val_cur;
    logic [14:0]        run_dist_reg, run_dist_next, run_dist_cur;
    logic [HIST_AW-1:0] wp_reg, wp_next, wp_cur;
    logic [HIST_CW-1:0] bw_reg, bw_next, bw_cur;

    logic               put, do_end, accept, dist_bad;
    logic [HIST_AW:0]   rd_full;
    logic [HIST_AW-1:0] rd_addr;
    step_t              s1, s2_reg;
    logic               s2_valid_reg;
    logic [7:0]         s2_byte, last_byte_reg, mem_q_reg;

    logic [7:0]         hist_mem [HIST_DEPTH];

    result_t            q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] q_wr_reg, q_rd_reg;
    logic [QUEUE_AW:0]  q_cnt_reg, q_cnt_next;
    logic               push, pop;

    assign accept = s_valid && s_ready;

    // A start request clears the parse state before the step is applied.
    always_comb begin
        if (s_start_req) begin
            ph_cur       = PH_CW_LO;
            ctrl_cur     = '0;
            blocks_cur   = '0;
            run_rem_cur  = '0;
            run_val_cur  = '0;
            run_dist_cur = '0;
            wp_cur       = '0;
            bw_cur       = '0;
        end else begin
            ph_cur       = phase_reg;
            ctrl_cur     = ctrl_reg;
            blocks_cur   = blocks_reg;
            run_rem_cur  = run_rem_reg;
            run_val_cur  = run_val_reg;
            run_dist_cur = run_dist_reg;
            wp_cur       = wp_reg;
            bw_cur       = bw_reg;
        end
    end

    // Copy source position and distance check.
    always_comb begin
        dist_bad = (run_dist_cur == '0) ||
                   ({{(HIST_CW + 1){1'b0}}, run_dist_cur} >
                    {{16{1'b0}}, bw_cur});
        if ({{(16 - HIST_AW){1'b0}}, wp_cur} >= {1'b0, run_dist_cur})
            rd_full = (HIST_AW + 1)'({1'b0, wp_cur} - (HIST_AW + 1)'(run_dist_cur));
        else
            rd_full = (HIST_AW + 1)'({1'b0, wp_cur} + (HIST_AW + 1)'(HIST_DEPTH)
                                      - (HIST_AW + 1)'(run_dist_cur));
        rd_addr = rd_full[HIST_AW-1:0];
    end

    assign blocks_dec = (blocks_cur != '0) ? blocks_cur - 4'd1 : 4'd0;

    // Next state of the parser.
    always_comb begin
        phase_next    = ph_cur;
        ctrl_next     = ctrl_cur;
        blocks_next   = blocks_cur;
        run_rem_next  = run_rem_cur;
        run_val_next  = run_val_cur;
        run_dist_next = run_dist_cur;
        put           = 1'b0;
        do_end        = 1'b0;
        if (ph_cur == PH_RUN_REP || ph_cur == PH_RUN_COPY) begin
            put          = 1'b1;
            run_rem_next = run_rem_cur - 15'd1;
            do_end       = (run_rem_next == '0);
        end else if (s_in_valid) begin
            case (ph_cur)
                PH_CW_HI: begin
                    ctrl_next   = {s_in_byte, ctrl_cur[7:0]};
                    blocks_next = 4'd8;
                    phase_next  = PH_BLOCK;
                end
                PH_BLOCK: begin
                    case (block_type_t'(ctrl_cur[1:0]))
                        BT_LIT_BYTE: begin
                            put    = 1'b1;
                            do_end = 1'b1;
                        end
                        BT_LIT_WORD: begin
                            put        = 1'b1;
                            phase_next = PH_LITW2;
                        end
                        BT_REPEAT: begin
                            run_rem_next = {8'd0, s_in_byte[6:0]};
                            phase_next   = s_in_byte[7] ? PH_REP_LEN_HI : PH_REP_VAL;
                        end
                        default: begin
                            run_rem_next = {8'd0, s_in_byte[6:0]};
                            phase_next   = s_in_byte[7] ? PH_COPY_LEN_HI : PH_COPY_DIST_LO;
                        end
                    endcase
                end
                PH_LITW2: begin
                    put    = 1'b1;
                    do_end = 1'b1;
                end
                PH_REP_LEN_HI: begin
                    run_rem_next = run_rem_cur | {s_in_byte, 7'd0};
                    phase_next   = PH_REP_VAL;
                end
                PH_REP_VAL: begin
                    run_val_next = s_in_byte;
                    if (run_rem_cur == '0)
                        do_end = 1'b1;
                    else
                        phase_next = PH_RUN_REP;
                end
                PH_COPY_LEN_HI: begin
                    run_rem_next = run_rem_cur | {s_in_byte, 7'd0};
                    phase_next   = PH_COPY_DIST_LO;
                end
                PH_COPY_DIST_LO: begin
                    run_dist_next = {8'd0, s_in_byte[6:0]};
                    if (s_in_byte[7])
                        phase_next = PH_COPY_DIST_HI;
                    else if (run_rem_cur == '0)
                        do_end = 1'b1;
                    else
                        phase_next = PH_RUN_COPY;
                end
                PH_COPY_DIST_HI: begin
                    run_dist_next = run_dist_cur | {s_in_byte, 7'd0};
                    if (run_rem_cur == '0)
                        do_end = 1'b1;
                    else
                        phase_next = PH_RUN_COPY;
                end
                default: begin
                    ctrl_next  = {8'd0, s_in_byte};
                    phase_next = PH_CW_HI;
                end
            endcase
        end
        if (do_end) begin
            ctrl_next   = {2'd0, ctrl_cur[15:2]};
            blocks_next = blocks_dec;
            phase_next  = (blocks_dec == '0) ? PH_CW_LO : PH_BLOCK;
        end
    end

    always_comb begin
        wp_next = wp_cur;
        bw_next = bw_cur;
        if (put) begin
            wp_next = (wp_cur == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
            if (bw_cur < HIST_CW'(HIST_DEPTH))
                bw_next = bw_cur + 1'b1;
        end
    end

    // Outputs of the parse stage.
    always_comb begin
        s1            = '0;
        s1.addr       = wp_cur;
        s1.run_active = (phase_next == PH_RUN_REP) || (phase_next == PH_RUN_COPY);
        case (ph_cur)
            PH_RUN_REP: begin
                s1.ov  = 1'b1;
                s1.val = run_val_cur;
            end
            PH_RUN_COPY: begin
                s1.ov = 1'b1;
                if (dist_bad)
                    s1.bad = 1'b1;
                else
                    s1.copy_rd = 1'b1;
            end
            default: begin
                if (s_in_valid) begin
                    s1.taken = 1'b1;
                    if (ph_cur == PH_LITW2 || (ph_cur == PH_BLOCK &&
                        (ctrl_cur[1:0] == BT_LIT_BYTE || ctrl_cur[1:0] == BT_LIT_WORD))) begin
                        s1.ov  = 1'b1;
                        s1.val = s_in_byte;
                    end
                end
            end
        endcase
        // The step ahead writes this very entry in the same cycle.
        s1.fwd = s1.copy_rd && s2_valid_reg && s2_reg.ov && (rd_addr == s2_reg.addr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CW_LO;
            ctrl_reg     <= '0;
            blocks_reg   <= '0;
            run_rem_reg  <= '0;
            run_val_reg  <= '0;
            run_dist_reg <= '0;
            wp_reg       <= '0;
            bw_reg       <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= accept;
            if (accept) begin
                phase_reg    <= phase_next;
                ctrl_reg     <= ctrl_next;
                blocks_reg   <= blocks_next;
                run_rem_reg  <= run_rem_next;
                run_val_reg  <= run_val_next;
                run_dist_reg <= run_dist_next;
                wp_reg       <= wp_next;
                bw_reg       <= bw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept)
            s2_reg <= s1;
        if (s2_valid_reg)
            last_byte_reg <= s2_byte;
    end

    assign s2_byte = s2_reg.copy_rd ? (s2_reg.fwd ? last_byte_reg : mem_q_reg) : s2_reg.val;

    // History memory: read in the parse stage, written once the byte is known.
    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_reg.ov)
            hist_mem[s2_reg.addr] <= s2_byte;
        if (accept && s1.copy_rd)
            mem_q_reg <= hist_mem[rd_addr];
    end

    // Result queue.
    assign push    = s2_valid_reg;
    assign pop     = m_valid && m_ready;
    assign m_valid = (q_cnt_reg != '0);
    assign s_ready = ((q_cnt_reg + {{QUEUE_AW{1'b0}}, s2_valid_reg}) <=
                      (QUEUE_AW + 1)'(QUEUE_DEPTH - 1));

    always_comb begin
        q_cnt_next = q_cnt_reg;
        if (push && !pop)
            q_cnt_next = q_cnt_reg + 1'b1;
        else if (pop && !push)
            q_cnt_next = q_cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
            if (push)
                q_wr_reg <= q_wr_reg + 1'b1;
            if (pop)
                q_rd_reg <= q_rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            q_mem[q_wr_reg] <= '{ov: s2_reg.ov, data: s2_byte, taken: s2_reg.taken,
                                 bad: s2_reg.bad, run_active: s2_reg.run_active};
    end

    assign m_out_valid    = q_mem[q_rd_reg].ov;
    assign m_out_byte     = q_mem[q_rd_reg].data;
    assign m_in_taken     = q_mem[q_rd_reg].taken;
    assign m_bad_distance = q_mem[q_rd_reg].bad;
    assign m_run_active   = q_mem[q_rd_reg].run_active;

endmodule

// ===== rtl/lzcwd_checker.sv =====
// ----------------------------------------------------------------------------
// LZ control word decompressor checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzcwd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_in_valid,
    input logic [7:0] s_in_byte,
    input logic       s_start_req,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_out_valid,
    input logic [7:0] m_out_byte,
    input logic       m_in_taken,
    input logic       m_bad_distance,
    input logic       m_run_active
);

    // The result queue is empty right after reset.
    `ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> !m_valid)

    // A word without a decoded byte carries a zero byte.
    `ASSERT_CLKD(a_idle_byte_zero, aclk, aresetn, m_valid && !m_out_valid |-> m_out_byte == 8'd0)

    // A bad copy byte is emitted as zero and never consumes input.
    `ASSERT_CLKD(a_bad_copy, aclk, aresetn, m_valid && m_bad_distance |-> m_out_valid && m_out_byte == 8'd0 && !m_in_taken)

    // A stalled result holds.
    `ASSERT_CLKD(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte))

endmodule

bind lz_control_word_decompressor_core lzcwd_checker u_lzcwd_checker (.*);
